/* rtl/sle_pkg.sv */
// Shared types, operation codes and sizing constants for the sorted list engine.
package sle_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int VALUE_W      = 32;
	localparam int KIND_W       = 2;
	localparam int POS_W        = 4;
	localparam int CNT_W        = 5;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] count;
		logic             full_reject;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic step;
		logic fin;
	} sle_cmd_t;

	typedef struct packed {
		logic skip;
		logic more;
		logic stop;
	} sle_status_t;

endpackage

/* rtl/sle_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module sle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/sle_dpath.sv */
// Datapath of the sorted list engine: entry store, scan pointer, count and result register.
module sle_dpath import sle_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        req,
	input  sle_cmd_t    cmd,
	output sle_status_t status,
	output rsp_t        rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [KIND_W-1:0]         kind_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [CW-1:0]             p_q;
	logic [CW-1:0]             idx_q;
	logic                      matched_q;
	logic [CW-1:0]             occ_q;
	rsp_t                      rsp_q;

	logic                      is_ins;
	logic                      is_rem;
	logic                      is_srch;
	logic                      full;
	logic [CW-1:0]             pm1;
	logic [VALUE_W-1:0]        rdata;
	logic                      ge;
	logic                      eq;
	logic                      we;
	logic [AW-1:0]             waddr;
	logic [VALUE_W-1:0]        wdata;
	logic [AW-1:0]             raddr;
	logic [CW-1:0]             occ_next;
	logic [CW-1:0]             pos_sel;

	assign is_ins  = (kind_q == KIND_INSERT);
	assign is_rem  = (kind_q == KIND_REMOVE);
	assign is_srch = (kind_q == KIND_SEARCH);
	assign full    = (occ_q == CW'(CAPACITY));
	assign pm1     = p_q - CW'(1);
	assign ge      = ($signed(rdata) >= value_q);
	assign eq      = (rdata == value_q);

	assign status.more = is_ins ? (p_q != '0) : (p_q < occ_q);
	assign status.skip = (is_ins && full) || !(is_ins || is_rem || is_srch);
	assign status.stop = is_ins ? !ge : (is_srch && eq);

	assign raddr = is_ins ? pm1[AW-1:0] : p_q[AW-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = p_q[AW-1:0];
		wdata = rdata;
		if (cmd.step && is_ins && ge) begin
			we = 1'b1;
		end else if (cmd.step && is_rem && matched_q) begin
			we    = 1'b1;
			waddr = pm1[AW-1:0];
		end else if (cmd.fin && is_ins && !full) begin
			we    = 1'b1;
			wdata = value_q;
		end
	end

	always_comb begin
		occ_next = occ_q;
		pos_sel  = '0;
		if (is_ins && !full) begin
			occ_next = occ_q + CW'(1);
			pos_sel  = p_q;
		end else if (is_rem && matched_q) begin
			occ_next = occ_q - CW'(1);
			pos_sel  = idx_q;
		end else if (is_srch && matched_q) begin
			pos_sel = idx_q;
		end
	end

	sle_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= req.kind;
			value_q <= req.value;
		end
		if (cmd.fin) begin
			rsp_q.found       <= (is_rem || is_srch) && matched_q;
			rsp_q.position    <= POS_W'(pos_sel);
			rsp_q.count       <= CNT_W'(occ_next);
			rsp_q.full_reject <= is_ins && full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q       <= '0;
			idx_q     <= '0;
			matched_q <= 1'b0;
			occ_q     <= '0;
		end else begin
			if (cmd.load) begin
				p_q       <= (req.kind == KIND_INSERT) ? occ_q : '0;
				idx_q     <= '0;
				matched_q <= 1'b0;
			end else if (cmd.step) begin
				if (is_ins) begin
					if (ge) begin
						p_q <= pm1;
					end
				end else if (is_rem) begin
					if (!matched_q && eq) begin
						matched_q <= 1'b1;
						idx_q     <= p_q;
					end
					p_q <= p_q + CW'(1);
				end else if (eq) begin
					matched_q <= 1'b1;
					idx_q     <= p_q;
				end else begin
					p_q <= p_q + CW'(1);
				end
			end
			if (cmd.fin) begin
				occ_q <= occ_next;
			end
		end
	end

	assign rsp = rsp_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(CAPACITY))
		else $error("stored count exceeds capacity");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin && is_ins && !full |=> occ_q == $past(occ_q) + CW'(1))
		else $error("accepted insert did not raise the count by one");

	a_rem_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin && is_rem && matched_q |=> occ_q == $past(occ_q) - CW'(1))
		else $error("matched remove did not lower the count by one");

endmodule

/* rtl/sle_ctrl.sv */
// Controller state machine of the sorted list engine: sequences scan, shift and result handoff.
module sle_ctrl import sle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	input  sle_status_t status,
	output sle_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       rsp_valid_q;
	logic       rsp_free;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_RD;
				end
			end
			ST_RD: begin
				if (status.skip || !status.more) begin
					state_next = ST_FIN;
				end else begin
					cmd.rd     = 1'b1;
					state_next = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.step   = 1'b1;
				state_next = status.stop ? ST_FIN : ST_RD;
			end
			ST_FIN: begin
				if (rsp_free) begin
					cmd.fin    = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.fin) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.rd, cmd.step, cmd.fin}))
		else $error("more than one datapath command in a cycle");

	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> rsp_valid)
		else $error("finished operation did not raise the result beat");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !(rsp_valid_q && rsp_stall))
		else $error("result register overwritten while still stalled");

endmodule

/* rtl/sorted_list_engine.sv */
// Top level of the sorted list engine: a bounded ascending multiset of signed values.
// Each request scans the stored entries in turn: insert stops at the first entry below
// the value, search at the match, and remove examines every stored entry.
// A new request beat is taken once the previous result sits in the output register.
// Reset clears the count and control state; stored values are undefined until written.
module sorted_list_engine import sle_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	sle_cmd_t    cmd;
	sle_status_t status;

	sle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status   (status),
		.cmd      (cmd)
	);

	sle_dpath #(
		.CAPACITY(CAPACITY)
	) u_dpath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.status(status),
		.rsp   (rsp)
	);

endmodule

/* test/tb_top.sv */
// Testbench for the sorted list engine: random and directed list operations checked beat by beat.
`timescale 1ns / 100ps

module tb_top;
	import sle_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam int STYLE_FILL  = 0;
	localparam int STYLE_MIXED = 1;
	localparam int STYLE_DRAIN = 2;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 160;
	localparam int POOL_N      = 8;
	localparam int SETTLE_CYCLES = 2 * DEF_CAPACITY + 8;
	localparam int CYCLE_LIMIT = 1_000_000;

	class sorted_list_tracker;
		logic signed [VALUE_W-1:0] held[DEF_CAPACITY];
		int unsigned used;
		rsp_t pending_replies[$];
		int unsigned mismatches;
		int unsigned requests, inserts, refused, removes, searches, hits, misses;

		function void note_request(req_t r);
			rsp_t want;
			int slot;
			int i;
			want = '0;
			slot = 0;
			requests++;
			case (r.kind)
				KIND_INSERT: begin
					inserts++;
					if (used >= DEF_CAPACITY) begin
						want.full_reject = 1'b1;
						refused++;
					end else begin
						while (slot < used && r.value > held[slot])
							slot++;
						for (i = used; i > slot; i--)
							held[i] = held[i - 1];
						held[slot] = r.value;
						used++;
						want.position = POS_W'(slot);
					end
				end
				KIND_REMOVE, KIND_SEARCH: begin
					if (r.kind == KIND_REMOVE)
						removes++;
					else
						searches++;
					while (slot < used && held[slot] != r.value)
						slot++;
					if (slot < used) begin
						hits++;
						want.found = 1'b1;
						want.position = POS_W'(slot);
						if (r.kind == KIND_REMOVE) begin
							for (i = slot; i + 1 < used; i++)
								held[i] = held[i + 1];
							used--;
						end
					end else begin
						misses++;
					end
				end
				default: ;
			endcase
			want.count = CNT_W'(used);
			pending_replies.push_back(want);
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			mismatches++;
		endtask

		task check_reply(rsp_t got);
			rsp_t want;
			if (pending_replies.size() == 0) begin
				report_mismatch($sformatf("result beat %p with nothing outstanding", got));
				return;
			end
			want = pending_replies.pop_front();
			if (got.found !== want.found)
				report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
			if (got.position !== want.position)
				report_mismatch($sformatf("position %0d, expected %0d",
					got.position, want.position));
			if (got.count !== want.count)
				report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
			if (got.full_reject !== want.full_reject)
				report_mismatch($sformatf("full_reject %b, expected %b",
					got.full_reject, want.full_reject));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	sorted_list_tracker book = new();
	bit idle_on;
	int unsigned cycle_count;
	logic signed [VALUE_W-1:0] value_pool[POOL_N];

	sorted_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_request(input logic [KIND_W-1:0] kind,
			input logic signed [VALUE_W-1:0] value);
		req_t r;
		int gap;
		r.kind = kind;
		r.value = value;
		gap = idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall !== 1'b0);
		book.note_request(r);
	endtask

	task automatic wait_for_replies();
		req_valid <= 1'b0;
		while (book.pending_replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [KIND_W-1:0] pick_kind(int style);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return KIND_UNUSED;
		case (style)
			STYLE_FILL:  return roll < 75 ? KIND_INSERT : (roll < 88 ? KIND_REMOVE : KIND_SEARCH);
			STYLE_DRAIN: return roll < 20 ? KIND_INSERT : (roll < 80 ? KIND_REMOVE : KIND_SEARCH);
			default:     return roll < 42 ? KIND_INSERT : (roll < 72 ? KIND_REMOVE : KIND_SEARCH);
		endcase
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return value_pool[$urandom_range(0, POOL_N - 1)];
		if (roll < 7 && book.used > 0)
			return book.held[$urandom_range(0, book.used - 1)];
		return $urandom;
	endfunction

	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = idle_on ? $urandom_range(0, 7) : 0;
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				do @(posedge clk); while (rsp_valid !== 1'b1);
				repeat (gap - 1) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (rsp_valid !== 1'b1);
			book.check_reply(rsp);
		end
	end

	initial begin
		int p;
		int n;
		int i;
		int style;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		idle_on = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(KIND_SEARCH, 32'sd0);
		send_request(KIND_REMOVE, 32'sd5);
		send_request(KIND_UNUSED, 32'sd7);
		send_request(KIND_INSERT, VAL_MAX);
		send_request(KIND_INSERT, VAL_MIN);
		send_request(KIND_INSERT, 32'sd0);
		send_request(KIND_INSERT, 32'sd0);
		send_request(KIND_INSERT, -32'sd1);
		send_request(KIND_SEARCH, 32'sd0);
		send_request(KIND_SEARCH, VAL_MIN);
		send_request(KIND_SEARCH, VAL_MAX);
		send_request(KIND_SEARCH, 32'sd1);
		send_request(KIND_REMOVE, 32'sd0);
		send_request(KIND_SEARCH, 32'sd0);
		send_request(KIND_REMOVE, VAL_MAX);
		send_request(KIND_REMOVE, VAL_MAX);
		send_request(KIND_UNUSED, 32'sh5555_5555);
		send_request(KIND_INSERT, 32'sh5555_5555);
		send_request(KIND_INSERT, 32'shaaaa_aaaa);
		send_request(KIND_REMOVE, VAL_MIN);
		send_request(KIND_REMOVE, -32'sd1);
		send_request(KIND_REMOVE, 32'sd0);
		send_request(KIND_REMOVE, 32'sh5555_5555);
		send_request(KIND_REMOVE, 32'shaaaa_aaaa);
		wait_for_replies();

		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = 32'sd0;
		value_pool[3] = -32'sd1;
		for (p = 0; p < PHASES; p++) begin
			style = p % 3;
			idle_on = (p % 4) != 3;
			value_pool[4] = $signed($urandom_range(0, 20)) - 10;
			for (i = 5; i < POOL_N; i++)
				value_pool[i] = $urandom;
			for (n = 0; n < PHASE_ITEMS; n++)
				send_request(pick_kind(style), pick_value());
			// Let the list settle so the next phase starts with nothing in flight.
			wait_for_replies();
		end

		req_valid <= 1'b0;
		wait_for_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d requests: %0d inserts (%0d refused on a full list), %0d removes, %0d searches.",
			book.requests, book.inserts, book.refused, book.removes, book.searches);
		$display("Removes and searches matched %0d times and missed %0d times; %0d cycles.",
			book.hits, book.misses, cycle_count);
		if (book.mismatches == 0 && book.pending_replies.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
